// ----- hdl/i2rd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package i2rd_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int VALUE_W     = 32;
    localparam int SYM_W       = 8;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int DIGIT_BUF   = 32;
    localparam int BUF_IDX_W   = 5;
    localparam int CNT_W       = 6;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 64;

    localparam logic [1:0] REG_DIGIT_COUNT = 2'd0;
    localparam logic [1:0] REG_ALPHA_LOW   = 2'd1;
    localparam logic [1:0] REG_ALPHA_HIGH  = 2'd2;

    localparam logic [RADIX_W-1:0] RST_DIGIT_COUNT = 5'd10;
    // "01234567" and "89ABCDEF", first symbol in the lowest byte
    localparam logic [DATA_W-1:0]  RST_ALPHA_LOW   = 64'h3736_3534_3332_3130;
    localparam logic [DATA_W-1:0]  RST_ALPHA_HIGH  = 64'h4645_4443_4241_3938;

    localparam logic [SYM_W-1:0] SIGN_MINUS = 8'd45;
    localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'd43;

    // floor(2^32 / d); the quotient estimate from it is low by at most one
    function automatic logic [VALUE_W-1:0] recip(input logic [RADIX_W-1:0] d);
        logic [VALUE_W-1:0] r;
        case (d)
            5'd2:    r = 32'h8000_0000;
            5'd3:    r = 32'h5555_5555;
            5'd4:    r = 32'h4000_0000;
            5'd5:    r = 32'h3333_3333;
            5'd6:    r = 32'h2AAA_AAAA;
            5'd7:    r = 32'h2492_4924;
            5'd8:    r = 32'h2000_0000;
            5'd9:    r = 32'h1C71_C71C;
            5'd10:   r = 32'h1999_9999;
            5'd11:   r = 32'h1745_D174;
            5'd12:   r = 32'h1555_5555;
            5'd13:   r = 32'h13B1_3B13;
            5'd14:   r = 32'h1249_2492;
            5'd15:   r = 32'h1111_1111;
            5'd16:   r = 32'h1000_0000;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/integer_to_radix_digits.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Converts one signed 32-bit integer per beat into its text in the radix set by
// digit_count, one 8-bit character per output beat, most significant digit first,
// with m_is_last on the final character. Negative values get a leading '-'; the
// most negative value is converted exactly. If the alphabet is unusable (radix
// below 2 or above 16, a '+' or '-' among the symbols in use, or a repeated
// symbol) the input beat is taken and nothing is emitted. Each digit goes through three
// steps of the shared divide unit (reciprocal multiply, back-multiply, remainder
// correct), then the characters leave at one per cycle while m_ready is high and
// wait while it is low. s_ready is high only between items. The alphabet and
// digit_count sit behind an APB port at byte addresses 0, 8 and 16 with 64-bit data.
module integer_to_radix_digits (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [i2rd_pkg::VALUE_W-1:0] s_value,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [i2rd_pkg::SYM_W-1:0]         m_symbol,
    output logic                               m_is_last,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [i2rd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [i2rd_pkg::DATA_W-1:0]   pwdata,
    output logic [i2rd_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import i2rd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_QD,
        ST_REM,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                 state_reg,        state_next;
    logic [RADIX_W-1:0]     digit_count_reg,  digit_count_next;
    logic [DATA_W-1:0]      alpha_low_reg,    alpha_low_next;
    logic [DATA_W-1:0]      alpha_high_reg,   alpha_high_next;
    logic [VALUE_W-1:0]     mag_reg,          mag_next;
    logic                   neg_reg,          neg_next;
    logic [RADIX_W-1:0]     radix_reg,        radix_next;
    logic [VALUE_W-1:0]     recip_reg,        recip_next;
    logic [2*VALUE_W-1:0]   prod_reg,         prod_next;
    logic [VALUE_W-1:0]     quo_reg,          quo_next;
    logic [VALUE_W-1:0]     qd_reg,           qd_next;
    logic [CNT_W-1:0]       cnt_reg,          cnt_next;
    logic                   m_valid_reg,      m_valid_next;
    logic [SYM_W-1:0]       m_symbol_reg,     m_symbol_next;
    logic                   m_is_last_reg,    m_is_last_next;

    logic [DIGIT_W-1:0]     digit_buf_reg [DIGIT_BUF];

    logic [SYM_W-1:0]       sym [16];
    logic                   alpha_ok;
    logic                   cfg_wr;
    logic                   out_free;
    logic [2*VALUE_W-1:0]   prod;
    logic [VALUE_W+RADIX_W-1:0] qd_full;
    logic [VALUE_W-1:0]     rem_raw;
    logic                   rem_ge;
    logic [VALUE_W-1:0]     rem_fix;
    logic [VALUE_W-1:0]     quo_fix;
    logic [BUF_IDX_W-1:0]   rd_idx;
    logic [CNT_W-1:0]       cnt_inc;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sym[i]     = alpha_low_reg[8*i +: 8];
            sym[i + 8] = alpha_high_reg[8*i +: 8];
        end
    end

    // alphabet check over the symbols in use
    always_comb begin
        alpha_ok = (digit_count_reg >= 5'd2) &&
                   (digit_count_reg <= RADIX_W'(MAX_SYMBOLS));
        for (int i = 0; i < 16; i++) begin
            if (RADIX_W'(i) < digit_count_reg) begin
                if (sym[i] == SIGN_PLUS || sym[i] == SIGN_MINUS) begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < 16; j++) begin
                    if (RADIX_W'(j) < digit_count_reg && sym[j] == sym[i]) begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign cfg_wr   = psel && penable && pwrite;
    assign out_free = !m_valid_reg || m_ready;

    // shared divide unit
    assign prod    = mag_reg * recip_reg;
    assign qd_full = prod_reg[2*VALUE_W-1:VALUE_W] * radix_reg;
    assign rem_raw = mag_reg - qd_reg;
    assign rem_ge  = rem_raw >= {{(VALUE_W-RADIX_W){1'b0}}, radix_reg};
    assign rem_fix = rem_ge ? rem_raw - {{(VALUE_W-RADIX_W){1'b0}}, radix_reg} : rem_raw;
    assign quo_fix = rem_ge ? quo_reg + 32'd1 : quo_reg;
    assign cnt_inc = cnt_reg + 6'd1;
    assign rd_idx  = BUF_IDX_W'(cnt_reg - 6'd1);

    always_comb begin
        state_next       = state_reg;
        digit_count_next = digit_count_reg;
        alpha_low_next   = alpha_low_reg;
        alpha_high_next  = alpha_high_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        radix_next       = radix_reg;
        recip_next       = recip_reg;
        prod_next        = prod_reg;
        quo_next         = quo_reg;
        qd_next          = qd_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg;
        m_symbol_next    = m_symbol_reg;
        m_is_last_next   = m_is_last_reg;

        if (cfg_wr) begin
            case (paddr[4:3])
                REG_DIGIT_COUNT: digit_count_next = pwdata[RADIX_W-1:0];
                REG_ALPHA_LOW:   alpha_low_next   = pwdata;
                REG_ALPHA_HIGH:  alpha_high_next  = pwdata;
                default:         ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                // an unusable alphabet drops the beat
                if (s_valid && alpha_ok) begin
                    neg_next   = s_value[VALUE_W-1];
                    mag_next   = s_value[VALUE_W-1] ? 32'd0 - s_value : s_value;
                    radix_next = digit_count_reg;
                    recip_next = recip(digit_count_reg);
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = prod;
                state_next = ST_QD;
            end
            ST_QD: begin
                quo_next   = prod_reg[2*VALUE_W-1:VALUE_W];
                qd_next    = qd_full[VALUE_W-1:0];
                state_next = ST_REM;
            end
            ST_REM: begin
                mag_next = quo_fix;
                cnt_next = cnt_inc;
                if (quo_fix == 32'd0 || cnt_inc == CNT_W'(DIGIT_BUF)) begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_symbol_next  = SIGN_MINUS;
                    m_is_last_next = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_symbol_next  = sym[digit_buf_reg[rd_idx]];
                    m_is_last_next = (cnt_reg == 6'd1);
                    cnt_next       = cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            digit_count_reg <= RST_DIGIT_COUNT;
            alpha_low_reg   <= RST_ALPHA_LOW;
            alpha_high_reg  <= RST_ALPHA_HIGH;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            digit_count_reg <= digit_count_next;
            alpha_low_reg   <= alpha_low_next;
            alpha_high_reg  <= alpha_high_next;
            cnt_reg         <= cnt_next;
            m_valid_reg     <= m_valid_next;
        end
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        radix_reg     <= radix_next;
        recip_reg     <= recip_next;
        prod_reg      <= prod_next;
        quo_reg       <= quo_next;
        qd_reg        <= qd_next;
        m_symbol_reg  <= m_symbol_next;
        m_is_last_reg <= m_is_last_next;
    end

    // digits land least significant first
    always_ff @(posedge aclk) begin
        if (state_reg == ST_REM) begin
            digit_buf_reg[cnt_reg[BUF_IDX_W-1:0]] <= rem_fix[DIGIT_W-1:0];
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_symbol  = m_symbol_reg;
    assign m_is_last = m_is_last_reg;
    assign pready    = 1'b1;

    always_comb begin
        case (paddr[4:3])
            REG_DIGIT_COUNT: prdata = {{(DATA_W-RADIX_W){1'b0}}, digit_count_reg};
            REG_ALPHA_LOW:   prdata = alpha_low_reg;
            REG_ALPHA_HIGH:  prdata = alpha_high_reg;
            default:         prdata = '0;
        endcase
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DIGIT_BUF))
        else $error("digit count beyond buffer depth");

    a_estimate_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REM) |-> (qd_reg <= mag_reg))
        else $error("quotient estimate too high");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REM) |->
            (rem_fix < {{(VALUE_W-RADIX_W){1'b0}}, radix_reg}))
        else $error("digit not below radix after correction");

    a_bad_alpha_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !alpha_ok) |=> (state_reg == ST_IDLE))
        else $error("conversion started with unusable alphabet");

endmodule

`default_nettype wire

// ----- tb/integer_to_radix_digits_tb.sv -----
`timescale 1ns / 1ps

module integer_to_radix_digits_tb;
    import i2rd_pkg::*;

    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             is_last;
    } char_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic [SYM_W-1:0]          m_symbol;
    logic                      m_is_last;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    // local copy of the base registers
    logic [RADIX_W-1:0] cfg_count;
    logic [DATA_W-1:0]  cfg_low;
    logic [DATA_W-1:0]  cfg_high;

    char_t text_q[$];
    char_t head_char;
    int    err_count = 0;
    int    cycle_count = 0;
    int    rx_hold_req = 0;
    bit    tx_idle_en;
    bit    rx_idle_en;

    integer_to_radix_digits DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_symbol  (m_symbol),
        .m_is_last (m_is_last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [SYM_W-1:0] symbol_at(input logic [DIGIT_W-1:0] d);
        return d[3] ? cfg_high[8*d[2:0] +: 8] : cfg_low[8*d[2:0] +: 8];
    endfunction

    function automatic bit base_is_usable();
        logic [SYM_W-1:0] s;
        if (cfg_count < 2 || cfg_count > MAX_SYMBOLS) return 1'b0;
        for (int i = 0; i < cfg_count; i++) begin
            s = symbol_at(DIGIT_W'(i));
            if (s == SIGN_PLUS || s == SIGN_MINUS) return 1'b0;
            for (int j = i + 1; j < cfg_count; j++)
                if (symbol_at(DIGIT_W'(j)) == s) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Queue the characters that one accepted value must produce.
    function automatic void predict_text(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [DIGIT_W-1:0] digs [DIGIT_BUF];
        int nd;
        radix = VALUE_W'(cfg_count);
        if (!base_is_usable()) return;
        mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
        nd = 0;
        do begin
            digs[nd] = DIGIT_W'(mag % radix);
            mag = mag / radix;
            nd++;
        end while (mag != 0 && nd < DIGIT_BUF);
        if (raw[VALUE_W-1]) text_q.push_back(char_t'{symbol: SIGN_MINUS, is_last: 1'b0});
        for (int k = nd; k > 0; k--)
            text_q.push_back(char_t'{symbol: symbol_at(digs[k-1]), is_last: (k == 1)});
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < 50) $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (text_q.size() == 0) begin
                report_mismatch($sformatf("unexpected char %0d last=%0b", m_symbol, m_is_last));
            end else begin
                head_char = text_q.pop_front();
                if (m_symbol !== head_char.symbol)
                    report_mismatch($sformatf("symbol %0d, want %0d",
                                              m_symbol, head_char.symbol));
                if (m_is_last !== head_char.is_last)
                    report_mismatch($sformatf("is_last %0b, want %0b",
                                              m_is_last, head_char.is_last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d chars outstanding", text_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin : rx_proc
        int n;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req > 0) begin
                n = rx_hold_req;
                rx_hold_req = 0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 18);
            end else begin
                n = 0;
            end
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Leaves valid high after the beat; the next call or wait_drain moves it.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        predict_text(v);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (text_q.size() != 0) @(posedge aclk);
        // an item on an unusable base emits nothing, so give it time to retire
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_DIGIT_COUNT: cfg_count = data[RADIX_W-1:0];
            REG_ALPHA_LOW:   cfg_low   = data;
            REG_ALPHA_HIGH:  cfg_high  = data;
            default: ;
        endcase
    endtask

    task automatic apply_base(input logic [RADIX_W-1:0] count, input logic [127:0] alpha);
        wait_drain();
        write_reg(REG_DIGIT_COUNT, DATA_W'(count));
        write_reg(REG_ALPHA_LOW, alpha[63:0]);
        write_reg(REG_ALPHA_HIGH, alpha[127:64]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Distinct, sign-free symbols for the digits in use; anything above them.
    function automatic logic [127:0] random_alphabet(input int radix);
        logic [127:0] a;
        logic [7:0]   b;
        bit           clash;
        a = '0;
        for (int i = 0; i < 16; i++) begin
            if (i >= radix) begin
                b = 8'($urandom());
            end else begin
                do begin
                    b = 8'($urandom());
                    clash = (b == SIGN_PLUS) || (b == SIGN_MINUS);
                    for (int j = 0; j < i; j++)
                        if (a[8*j +: 8] == b) clash = 1'b1;
                end while (clash);
            end
            a[8*i +: 8] = b;
        end
        return a;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0: begin
                v = $urandom_range(0, 20);
                if ($urandom_range(0, 1)) v = ~v + 1'b1;
            end
            1: begin
                v = $urandom_range(0, 100000);
                if ($urandom_range(0, 1)) v = ~v + 1'b1;
            end
            2: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic logic [RADIX_W-1:0] random_radix();
        if ($urandom_range(0, 2) == 0) return $urandom_range(0, 1) ? 5'd2 : 5'd16;
        return RADIX_W'($urandom_range(2, 16));
    endfunction

    task automatic test_reset_base();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(-32'sd10);
        wait_drain();
    endtask

    task automatic test_binary();
        logic [127:0] alpha;
        alpha = {$urandom(), $urandom(), $urandom(), $urandom()};
        alpha[15:0] = 16'h3130;
        apply_base(5'd2, alpha);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd0);
    endtask

    // zero byte as digit 0, top bits of every byte lane toggled
    task automatic test_odd_symbols();
        apply_base(5'd16, {64'hFFFE_FDFC_FBFA_F9F8, 64'h0706_0504_0302_0100});
        send_value(32'd0);
        send_value(32'h89AB_CDEF);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FFFF);
    endtask

    task automatic test_bad_bases();
        logic [127:0] dflt;
        logic [127:0] alpha;
        dflt = {RST_ALPHA_HIGH, RST_ALPHA_LOW};
        apply_base(5'd0, dflt);
        send_value(-32'sd12345);
        apply_base(5'd1, dflt);
        send_value(32'd7);
        apply_base(5'd17, dflt);
        send_value(32'd99);
        apply_base(5'd31, dflt);
        send_value(32'h8000_0000);
        alpha = dflt;
        alpha[8*3 +: 8] = SIGN_PLUS;
        apply_base(5'd10, alpha);
        send_value(32'd77);
        alpha = dflt;
        alpha[8*9 +: 8] = SIGN_MINUS;
        apply_base(5'd10, alpha);
        send_value(-32'sd77);
        alpha = dflt;
        alpha[8*9 +: 8] = alpha[7:0];
        apply_base(5'd10, alpha);
        send_value(32'd5);
        apply_base(5'd16, '0);
        send_value(32'd1);
        // a sign symbol above the radix is harmless
        alpha = dflt;
        alpha[8*5 +: 8] = SIGN_PLUS;
        apply_base(5'd2, alpha);
        send_value(-32'sd5);
        apply_base(5'd8, {64'hFFFF_FFFF_FFFF_FFFF, RST_ALPHA_LOW});
        send_value(32'h8000_0000);
        wait_drain();
    endtask

    task automatic test_hold_off();
        logic [RADIX_W-1:0] count;
        count = random_radix();
        apply_base(count, random_alphabet(count));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_hold_req = 400;
        repeat (10) send_value(random_value());
        // hold the sender until every character is out
        wait_drain();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (6) send_value(random_value());
        wait_drain();
    endtask

    task automatic run_phase(input int n_items);
        logic [RADIX_W-1:0] count;
        logic [127:0]       alpha;
        int                 kind;
        int                 i;
        int                 j;
        kind  = $urandom_range(0, 9);
        count = random_radix();
        alpha = random_alphabet(count);
        case (kind)
            0: count = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                            : RADIX_W'($urandom_range(17, 31));
            1: begin
                i = $urandom_range(0, count - 1);
                alpha[8*i +: 8] = $urandom_range(0, 1) ? SIGN_PLUS : SIGN_MINUS;
            end
            2: begin
                j = $urandom_range(1, count - 1);
                i = $urandom_range(0, j - 1);
                alpha[8*j +: 8] = alpha[8*i +: 8];
            end
            default: ;
        endcase
        apply_base(count, alpha);
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
        if (kind <= 2) n_items = 4;
        for (int n = 0; n < n_items; n++) begin
            send_value(random_value());
            if ($urandom_range(0, 39) == 0) wait_drain();
        end
    endtask

    task automatic test_random_bases();
        repeat (12) run_phase(28);
        wait_drain();
    endtask

    task automatic test_steady_stream();
        logic [RADIX_W-1:0] count;
        count = random_radix();
        apply_base(count, random_alphabet(count));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (30) send_value(random_value());
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_value   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        cfg_count = RST_DIGIT_COUNT;
        cfg_low   = RST_ALPHA_LOW;
        cfg_high  = RST_ALPHA_HIGH;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_base();
        test_binary();
        test_odd_symbols();
        test_bad_bases();
        test_hold_off();
        test_random_bases();
        test_steady_stream();
        wait_drain();

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/i2rd_pkg.sv
hdl/integer_to_radix_digits.sv
tb/integer_to_radix_digits_tb.sv
